### rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, character codes and sizes for the path string tokenizer.
// ----------------------------------------------------------------------------
package pst_pkg;

    // Width of the decoded index accumulator
    localparam int INDEX_BITS  = 32;
    // Result index field width, fixed by the result beat format
    localparam int OUT_IDX_W   = 32;
    localparam int IDX_EXT_W   = (INDEX_BITS > OUT_IDX_W) ? INDEX_BITS : OUT_IDX_W;

    // Most results one input beat can cause
    localparam int MAX_RESULTS = 3;
    localparam int PUSH_W      = $clog2(MAX_RESULTS + 1);

    // Result queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LANGLE = 8'h3C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_RANGLE = 8'h3E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        K_BYTE = 3'd0,
        K_NEND = 3'd1,
        K_ARR  = 3'd2,
        K_LIST = 3'd3,
        K_OK   = 3'd4,
        K_FAIL = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        M_START  = 3'd0,
        M_NAME   = 3'd1,
        M_ESC    = 3'd2,
        M_IFIRST = 3'd3,
        M_IMORE  = 3'd4,
        M_ERR    = 3'd5
    } t_mode;

    typedef logic [IDX_EXT_W-1:0] t_idx_ext;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            char_value;
        logic [OUT_IDX_W-1:0]  index_value;
        logic                  last;
    } t_result;

    // Results produced by one accepted beat
    typedef struct packed {
        logic [PUSH_W-1:0]             count;
        t_result [MAX_RESULTS-1:0]     res;
    } t_push;

    function automatic t_result mk_result(t_kind kind, logic [7:0] ch,
                                          logic [OUT_IDX_W-1:0] idx);
        t_result r;
        r.kind        = kind;
        r.char_value  = ch;
        r.index_value = idx;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

### rtl/pst_in_if.sv
// ----------------------------------------------------------------------------
// pst_in_if
// Input channel: one path byte or an end marker per beat.
// ----------------------------------------------------------------------------
interface pst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_marker;

    modport source (output valid, output byte_value, output end_marker, input ready);
    modport sink   (input valid, input byte_value, input end_marker, output ready);
endinterface

### rtl/pst_out_if.sv
// ----------------------------------------------------------------------------
// pst_out_if
// Result channel: one token or status per beat.
// ----------------------------------------------------------------------------
interface pst_out_if
    import pst_pkg::*;
;
    logic                 valid;
    logic                 ready;
    t_kind                kind;
    logic [7:0]           char_value;
    logic [OUT_IDX_W-1:0] index_value;
    logic                 last;

    modport source (output valid, output kind, output char_value, output index_value,
                    output last, input ready);
    modport sink   (input valid, input kind, input char_value, input index_value,
                    input last, output ready);
endinterface

### rtl/pst_parser.sv
// ----------------------------------------------------------------------------
// pst_parser
// Parse state machine: updates mode, bracket and index on each accepted beat
// and forms the up to three results that the beat causes.
// ----------------------------------------------------------------------------
module pst_parser
    import pst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte_value,
    input  logic       i_end_marker,
    output t_push      o_push
);

    t_mode                 r_mode,    n_mode;
    logic                  r_bracket, n_bracket;
    logic [INDEX_BITS-1:0] r_accum,   n_accum;

    logic                  is_digit;
    logic                  is_first;
    logic                  is_open;
    logic [3:0]            digit;
    logic [INDEX_BITS+3:0] acc_mul;
    logic                  overflow;
    t_idx_ext              idx_ext;

    // Classify the byte and form accum * 10 + digit with headroom bits
    assign is_digit = (i_byte_value >= CH_ZERO) && (i_byte_value <= CH_NINE);
    assign is_first = (i_byte_value >= CH_ONE)  && (i_byte_value <= CH_NINE);
    assign is_open  = (i_byte_value == CH_LBRACK) || (i_byte_value == CH_LANGLE);
    assign digit    = i_byte_value[3:0];
    assign acc_mul  = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                    + {{INDEX_BITS{1'b0}}, digit};
    assign overflow = |acc_mul[INDEX_BITS+3:INDEX_BITS];
    assign idx_ext  = t_idx_ext'(r_accum);

    // Next state
    always_comb begin
        n_mode    = r_mode;
        n_bracket = r_bracket;
        n_accum   = r_accum;
        if (i_end_marker) begin
            n_mode    = M_START;
            n_bracket = 1'b0;
            n_accum   = '0;
        end else begin
            unique case (r_mode)
                M_START: begin
                    if (i_byte_value == CH_SLASH) begin
                        n_mode = M_NAME;
                    end else if (is_open) begin
                        n_bracket = (i_byte_value == CH_LANGLE);
                        n_accum   = '0;
                        n_mode    = M_IFIRST;
                    end else begin
                        n_mode = M_ERR;
                    end
                end
                M_NAME: begin
                    if (i_byte_value == CH_BSLASH) begin
                        n_mode = M_ESC;
                    end else if (is_open) begin
                        n_bracket = (i_byte_value == CH_LANGLE);
                        n_accum   = '0;
                        n_mode    = M_IFIRST;
                    end
                end
                M_ESC: begin
                    n_mode = M_NAME;
                end
                M_IFIRST: begin
                    if (is_first) begin
                        n_accum = INDEX_BITS'(digit);
                        n_mode  = M_IMORE;
                    end else begin
                        n_mode = M_ERR;
                    end
                end
                M_IMORE: begin
                    if (is_digit) begin
                        if (overflow) begin
                            n_mode = M_ERR;
                        end else begin
                            n_accum = acc_mul[INDEX_BITS-1:0];
                        end
                    end else if ((i_byte_value == CH_RBRACK && !r_bracket) ||
                                 (i_byte_value == CH_RANGLE && r_bracket)) begin
                        n_accum = '0;
                        n_mode  = M_START;
                    end else begin
                        n_mode = M_ERR;
                    end
                end
                default: begin
                    n_mode = M_ERR;
                end
            endcase
        end
    end

    // Results of this beat
    always_comb begin
        o_push.count = '0;
        o_push.res   = '0;
        if (i_accept) begin
            if (i_end_marker) begin
                unique case (r_mode)
                    M_START: begin
                        o_push.res[0] = mk_result(K_OK, 8'h00, '0);
                        o_push.count  = PUSH_W'(1);
                    end
                    M_NAME: begin
                        o_push.res[0] = mk_result(K_NEND, 8'h00, '0);
                        o_push.res[1] = mk_result(K_OK, 8'h00, '0);
                        o_push.count  = PUSH_W'(2);
                    end
                    M_ESC: begin
                        // trailing backslash is kept as a name byte
                        o_push.res[0] = mk_result(K_BYTE, CH_BSLASH, '0);
                        o_push.res[1] = mk_result(K_NEND, 8'h00, '0);
                        o_push.res[2] = mk_result(K_OK, 8'h00, '0);
                        o_push.count  = PUSH_W'(3);
                    end
                    default: begin
                        o_push.res[0] = mk_result(K_FAIL, 8'h00, '0);
                        o_push.count  = PUSH_W'(1);
                    end
                endcase
            end else begin
                unique case (r_mode)
                    M_NAME: begin
                        if (i_byte_value == CH_SLASH || is_open) begin
                            o_push.res[0] = mk_result(K_NEND, 8'h00, '0);
                            o_push.count  = PUSH_W'(1);
                        end else if (i_byte_value != CH_BSLASH) begin
                            o_push.res[0] = mk_result(K_BYTE, i_byte_value, '0);
                            o_push.count  = PUSH_W'(1);
                        end
                    end
                    M_ESC: begin
                        o_push.res[0] = mk_result(K_BYTE, i_byte_value, '0);
                        o_push.count  = PUSH_W'(1);
                    end
                    M_IMORE: begin
                        if (i_byte_value == CH_RBRACK && !r_bracket) begin
                            o_push.res[0] = mk_result(K_ARR, 8'h00,
                                                      idx_ext[OUT_IDX_W-1:0]);
                            o_push.count  = PUSH_W'(1);
                        end else if (i_byte_value == CH_RANGLE && r_bracket) begin
                            o_push.res[0] = mk_result(K_LIST, 8'h00,
                                                      idx_ext[OUT_IDX_W-1:0]);
                            o_push.count  = PUSH_W'(1);
                        end
                    end
                    default: begin
                        o_push.count = '0;
                    end
                endcase
            end
            // flag the final result of the beat
            for (int k = 0; k < MAX_RESULTS; k++) begin
                o_push.res[k].last = (o_push.count == PUSH_W'(k + 1));
            end
        end
    end

    // Hold state between beats, advance on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_START;
            r_bracket <= 1'b0;
            r_accum   <= '0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_bracket <= n_bracket;
            r_accum   <= n_accum;
        end
    end

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_marker) |=> (r_mode == M_START && r_accum == '0 && !r_bracket))
        else $error("state not cleared after end of path");

    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_marker) |-> (o_push.count != '0))
        else $error("end of path produced no status");

endmodule

### rtl/pst_result_fifo.sv
// ----------------------------------------------------------------------------
// pst_result_fifo
// Small result queue: takes up to three results per cycle, returns one
// per output beat.
// ----------------------------------------------------------------------------
module pst_result_fifo
    import pst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               pop;

    // Room for a whole beat's worth of results
    assign o_room   = (r_count <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && i_ready;

    // Pointer and fill updates
    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push.count);
        n_rd    = r_rd + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    // Write the beat's results at consecutive slots
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (PUSH_W'(k) < i_push.count) begin
                r_mem[PTR_W'(r_wr + PTR_W'(k))] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != '0) |-> o_room)
        else $error("results pushed without room in queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue count out of range");

endmodule

### rtl/path_string_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// path_string_tokenizer_unit
// Tokenizes a path string into name bytes, name ends, indices and a status.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  i_in    | in  | byte_value[7:0], end_marker
//  o_out   | out | kind[2:0], char_value[7:0], index_value[31:0], last
//
//  One input beat per cycle while i_in.ready is high; its results go to a four-entry result queue.
//  A beat causing k results needs k output beats, one per cycle while o_out.ready is high.
//  i_in.ready is high while at most one result waits in the queue.
//  Reset is synchronous and active low; no clearing pass.
//  Output stalls back up only through the queue fill.
// ----------------------------------------------------------------------------
module path_string_tokenizer_unit
    import pst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    pst_in_if.sink    i_in,
    pst_out_if.source o_out
);

    logic    accept;
    logic    room;
    t_push   push;
    t_result result;

    // Accept a beat only when the queue can take all its results
    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    pst_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte_value (i_in.byte_value),
        .i_end_marker (i_in.end_marker),
        .o_push       (push)
    );

    pst_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (result)
    );

    // Drive the result beat
    assign o_out.kind        = result.kind;
    assign o_out.char_value  = result.char_value;
    assign o_out.index_value = result.index_value;
    assign o_out.last        = result.last;

endmodule

### test/path_string_tokenizer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_string_tokenizer_unit_test
// Self-checking bench for the path tokenizer. A short table of directed beats
// covers empty paths, bad starts, escapes, trailing backslashes and bad or
// unfinished indices. Random paths follow: mostly well-formed, some corrupted,
// some noise. Every result beat is compared with its typed row or a local tokenizer model.
// Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module path_string_tokenizer_unit_test
    import pst_pkg::*;
;

    localparam int RAND_BEATS = 320;
    localparam int QUIET_TAIL = 60;

    // One stimulus beat; typed rows carry their own expectation
    typedef struct packed {
        logic [7:0]           b;
        logic                 e;
        logic                 typed;
        logic                 one_res;
        t_kind                k;
        logic [OUT_IDX_W-1:0] idx;
    } t_row;

    localparam int N_ROWS = 32;

    // Directed table: byte, end marker, typed, one result, kind, index
    t_row dir_rows [N_ROWS] = '{
        '{8'h00,     1'b1, 1'b1, 1'b1, K_OK,   32'd0},  // empty path
        '{8'h71,     1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},  // bad component start
        '{8'hFF,     1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},  // ignored in error mode
        '{8'hFF,     1'b1, 1'b1, 1'b1, K_FAIL, 32'd0},
        '{CH_SLASH,  1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{8'h00,     1'b0, 1'b0, 1'b0, K_BYTE, 32'd0},  // lowest name byte
        '{8'hFF,     1'b0, 1'b0, 1'b0, K_BYTE, 32'd0},  // highest name byte
        '{CH_BSLASH, 1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{CH_LBRACK, 1'b0, 1'b0, 1'b0, K_BYTE, 32'd0},  // escaped bracket
        '{CH_SLASH,  1'b0, 1'b0, 1'b0, K_BYTE, 32'd0},
        '{CH_LANGLE, 1'b0, 1'b0, 1'b0, K_BYTE, 32'd0},  // empty name, then list
        '{CH_ONE,    1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{CH_RANGLE, 1'b0, 1'b1, 1'b1, K_LIST, 32'd1},
        '{CH_LBRACK, 1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{CH_NINE,   1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{CH_ZERO,   1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{CH_RBRACK, 1'b0, 1'b1, 1'b1, K_ARR,  32'd90},
        '{CH_SLASH,  1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{CH_BSLASH, 1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{8'h00,     1'b1, 1'b0, 1'b0, K_BYTE, 32'd0},  // trailing backslash kept
        '{CH_LBRACK, 1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{CH_ZERO,   1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},  // leading zero
        '{8'h00,     1'b1, 1'b1, 1'b1, K_FAIL, 32'd0},
        '{CH_LANGLE, 1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{8'h35,     1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{CH_RBRACK, 1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},  // wrong closer
        '{8'h00,     1'b1, 1'b1, 1'b1, K_FAIL, 32'd0},
        '{CH_LBRACK, 1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{8'h37,     1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{8'h00,     1'b1, 1'b1, 1'b1, K_FAIL, 32'd0},  // path ends inside index
        '{CH_SLASH,  1'b0, 1'b1, 1'b0, K_BYTE, 32'd0},
        '{8'h00,     1'b1, 1'b0, 1'b0, K_BYTE, 32'd0}   // empty name at end
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pst_in_if  in_ch();
    pst_out_if out_ch();

    path_string_tokenizer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Tokenizer model state
    t_mode                 tok_mode = M_START;
    logic                  tok_list = 1'b0;
    logic [INDEX_BITS-1:0] tok_acc  = '0;

    t_result token_q[$];
    t_result beat_res[$];
    t_row    path_q[$];

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int sink_hold    = 0;

    int fault_cnt   = 0;
    int beats_sent  = 0;
    int paths_sent  = 0;
    int seen_total  = 0;
    int seen_bytes  = 0;
    int seen_index  = 0;
    int seen_ok     = 0;
    int seen_fail   = 0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results pending", token_q.size());
        $display("[path_string_tokenizer_unit] ERROR");
        $finish;
    end

    function automatic void emit(t_kind k, logic [7:0] ch, logic [OUT_IDX_W-1:0] idx);
        t_result r;
        r.kind        = k;
        r.char_value  = ch;
        r.index_value = idx;
        r.last        = 1'b0;
        beat_res = {beat_res, r};
    endfunction

    function automatic void open_index(logic [7:0] b);
        tok_list = (b == CH_LANGLE);
        tok_acc  = '0;
        tok_mode = M_IFIRST;
    endfunction

    // Advance the model by one beat and collect the results it causes
    function automatic void tokenize_beat(logic [7:0] b, logic e);
        logic [INDEX_BITS+3:0] grown;
        beat_res.delete();
        if (e) begin
            case (tok_mode)
                M_START: emit(K_OK, 8'h00, '0);
                M_NAME: begin
                    emit(K_NEND, 8'h00, '0);
                    emit(K_OK, 8'h00, '0);
                end
                M_ESC: begin
                    emit(K_BYTE, CH_BSLASH, '0);
                    emit(K_NEND, 8'h00, '0);
                    emit(K_OK, 8'h00, '0);
                end
                default: emit(K_FAIL, 8'h00, '0);
            endcase
            tok_mode = M_START;
            tok_list = 1'b0;
            tok_acc  = '0;
        end else begin
            case (tok_mode)
                M_START: begin
                    if (b == CH_SLASH) tok_mode = M_NAME;
                    else if (b == CH_LBRACK || b == CH_LANGLE) open_index(b);
                    else tok_mode = M_ERR;
                end
                M_NAME: begin
                    if (b == CH_BSLASH) begin
                        tok_mode = M_ESC;
                    end else if (b == CH_SLASH) begin
                        emit(K_NEND, 8'h00, '0);
                    end else if (b == CH_LBRACK || b == CH_LANGLE) begin
                        emit(K_NEND, 8'h00, '0);
                        open_index(b);
                    end else begin
                        emit(K_BYTE, b, '0);
                    end
                end
                M_ESC: begin
                    emit(K_BYTE, b, '0);
                    tok_mode = M_NAME;
                end
                M_IFIRST: begin
                    if (b >= CH_ONE && b <= CH_NINE) begin
                        tok_acc  = INDEX_BITS'(b - CH_ZERO);
                        tok_mode = M_IMORE;
                    end else begin
                        tok_mode = M_ERR;
                    end
                end
                M_IMORE: begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        // Flag overflow instead of wrapping
                        grown = {4'b0000, tok_acc} * (INDEX_BITS+4)'(10)
                              + (INDEX_BITS+4)'(b - CH_ZERO);
                        if (grown[INDEX_BITS+3:INDEX_BITS] != '0) tok_mode = M_ERR;
                        else tok_acc = grown[INDEX_BITS-1:0];
                    end else if (b == CH_RBRACK && !tok_list) begin
                        emit(K_ARR, 8'h00, OUT_IDX_W'(tok_acc));
                        tok_acc  = '0;
                        tok_mode = M_START;
                    end else if (b == CH_RANGLE && tok_list) begin
                        emit(K_LIST, 8'h00, OUT_IDX_W'(tok_acc));
                        tok_acc  = '0;
                        tok_mode = M_START;
                    end else begin
                        tok_mode = M_ERR;
                    end
                end
                default: ;
            endcase
        end
        if (beat_res.size() > 0) beat_res[beat_res.size()-1].last = 1'b1;
    endfunction

    // Drive one beat, wait for the handshake, then log what it should cause
    task automatic send_beat(input t_row row);
        t_result fixed;
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= row.b;
        in_ch.end_marker <= row.e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tokenize_beat(row.b, row.e);
        if (!row.typed) begin
            token_q = {token_q, beat_res};
        end else if (row.one_res) begin
            fixed.kind        = row.k;
            fixed.char_value  = 8'h00;
            fixed.index_value = row.idx;
            fixed.last        = 1'b1;
            token_q = {token_q, fixed};
        end
        beats_sent++;
        if (row.e) paths_sent++;
        // Idle the sender now and then
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every pending result has come out
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (token_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic void put_char(logic [7:0] b, logic e);
        t_row r;
        r = '{b, e, 1'b0, 1'b0, K_BYTE, '0};
        path_q = {path_q, r};
    endfunction

    function automatic void put_decimal(logic [63:0] v);
        logic [7:0]  digs[$];
        logic [63:0] rest;
        rest = v;
        if (rest == 64'd0) digs = {digs, CH_ZERO};
        while (rest != 64'd0) begin
            digs.push_front(CH_ZERO + 8'(rest % 64'd10));
            rest = rest / 64'd10;
        end
        foreach (digs[i]) put_char(digs[i], 1'b0);
    endfunction

    // Index values: small, full range, the top value, just past it, huge
    function automatic logic [63:0] pick_index();
        logic [63:0] top;
        logic [63:0] v;
        top = 64'((65'd1 << INDEX_BITS) - 65'd1);
        case ($urandom_range(0, 7))
            0, 1, 2, 3: v = 64'($urandom_range(1, 99));
            4: v = {32'h0, $urandom};
            5: v = top;
            6: v = top + 64'd1 + 64'($urandom_range(0, 9));
            default: v = {$urandom, $urandom};
        endcase
        if (v == 64'd0) v = 64'd1;
        return v;
    endfunction

    // Build one path body (without its end beat) from valid components
    function automatic void build_path();
        int         n_comp;
        int         len;
        logic [7:0] c;
        bit         in_name;
        in_name = 1'b0;
        n_comp = $urandom_range(0, 4);
        repeat (n_comp) begin
            case ($urandom_range(0, 2))
                0: begin
                    put_char(CH_SLASH, 1'b0);
                    len = $urandom_range(0, 6);
                    repeat (len) begin
                        c = 8'($urandom_range(0, 255));
                        // Escape delimiters, and some plain bytes too
                        if (c == CH_SLASH || c == CH_LBRACK || c == CH_LANGLE ||
                            c == CH_BSLASH || $urandom_range(0, 7) == 0) begin
                            put_char(CH_BSLASH, 1'b0);
                        end
                        put_char(c, 1'b0);
                    end
                    in_name = 1'b1;
                end
                1: begin
                    put_char(CH_LBRACK, 1'b0);
                    put_decimal(pick_index());
                    put_char(CH_RBRACK, 1'b0);
                    in_name = 1'b0;
                end
                default: begin
                    put_char(CH_LANGLE, 1'b0);
                    put_decimal(pick_index());
                    put_char(CH_RANGLE, 1'b0);
                    in_name = 1'b0;
                end
            endcase
        end
        if (in_name && $urandom_range(0, 3) == 0) put_char(CH_BSLASH, 1'b0);
    endfunction

    // Random path: mostly well-formed, some corrupted, some noise
    function automatic bit gen_path();
        int p;
        bit noise;
        path_q.delete();
        noise = 1'b0;
        case ($urandom_range(0, 9))
            0: begin
                noise = 1'b1;
                repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(0, 255)), 1'b0);
            end
            1, 2: begin
                build_path();
                if (path_q.size() > 0) begin
                    p = $urandom_range(0, path_q.size() - 1);
                    path_q[p].b = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1) == 1) begin
                        while (path_q.size() > p + 1) void'(path_q.pop_back());
                    end
                end
            end
            default: build_path();
        endcase
        put_char(8'($urandom_range(0, 255)), 1'b1);
        return noise;
    endfunction

    function automatic void note_fault(string what, t_result want, t_result got);
        fault_cnt++;
        if (fault_cnt <= 10) begin
            $display("%0t %s: expected kind=%0d char=%02h index=%0d last=%0b",
                     $realtime, what, want.kind, want.char_value, want.index_value, want.last);
            $display("%0t %s:      got kind=%0d char=%02h index=%0d last=%0b",
                     $realtime, what, got.kind, got.char_value, got.index_value, got.last);
        end
    endfunction

    // Result side: stall in random bursts
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
            out_ch.ready <= 1'b0;
            sink_hold    <= $urandom_range(1, 16) - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest pending expectation
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.kind        = out_ch.kind;
            got.char_value  = out_ch.char_value;
            got.index_value = out_ch.index_value;
            got.last        = out_ch.last;
            seen_total++;
            case (got.kind)
                K_BYTE: seen_bytes++;
                K_ARR, K_LIST: seen_index++;
                K_OK: seen_ok++;
                K_FAIL: seen_fail++;
                default: ;
            endcase
            if (token_q.size() == 0) begin
                note_fault("result with nothing pending", got, got);
            end else begin
                want = token_q.pop_front();
                if (got.kind !== want.kind || got.char_value !== want.char_value ||
                    got.index_value !== want.index_value || got.last !== want.last) begin
                    note_fault("result mismatch", want, got);
                end
            end
        end
    end

    initial begin : stimulus
        int rand_beats;
        bit mid_drained;
        bit noise;
        rand_beats  = 0;
        mid_drained = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.byte_value = 8'h00;
        in_ch.end_marker = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (dir_rows[i]) send_beat(dir_rows[i]);
        drain_results();

        // Random paths
        while (rand_beats < RAND_BEATS) begin
            noise = gen_path();
            foreach (path_q[i]) send_beat(path_q[i]);
            if (!noise) rand_beats += path_q.size();
            if (!mid_drained && rand_beats >= RAND_BEATS / 2) begin
                drain_results();
                mid_drained = 1'b1;
            end
            // Run the last stretch at full rate on both sides
            if (rand_beats >= RAND_BEATS - QUIET_TAIL) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
        end
        in_ch.valid <= 1'b0;

        while (token_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (token_q.size() != 0) fault_cnt += token_q.size();

        $display("Sent %0d beats over %0d paths; checked %0d results", beats_sent, paths_sent,
                 seen_total);
        $display("  %0d name bytes, %0d indices, %0d ok, %0d error status, %0d faults",
                 seen_bytes, seen_index, seen_ok, seen_fail, fault_cnt);
        if (fault_cnt == 0) begin
            $display("[path_string_tokenizer_unit] OK");
        end else begin
            $display("[path_string_tokenizer_unit] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pst_pkg.sv
rtl/pst_in_if.sv
rtl/pst_out_if.sv
rtl/pst_parser.sv
rtl/pst_result_fifo.sv
rtl/path_string_tokenizer_unit.sv
test/path_string_tokenizer_unit_test.sv
